@@ hdl/blpq_pkg.sv @@
// Package with the shared constants and command codes of the byte-limited packet queue.
`timescale 1ns / 1ps

package blpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int HANDLE_W    = 16;
   localparam int LENGTH_W    = 16;
   localparam int BYTES_W     = 24;
   localparam int DESC_W      = HANDLE_W + LENGTH_W;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_PURGE = 2'd3
   } command_type;

endpackage

@@ hdl/blpq_req_if.sv @@
// Request channel interface that carries one queue command word.
`timescale 1ns / 1ps

interface blpq_req_if;
   import blpq_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [HANDLE_W-1:0] packet_handle;
   logic [LENGTH_W-1:0] packet_length;

   modport source (output valid, command, packet_handle, packet_length, input ready);
   modport sink   (input valid, command, packet_handle, packet_length, output ready);
endinterface

@@ hdl/blpq_rsp_if.sv @@
// Response channel interface that carries one queue result word.
`timescale 1ns / 1ps

interface blpq_rsp_if;
   import blpq_pkg::*;

   logic                valid;
   logic                ready;
   logic                done_res;
   logic [HANDLE_W-1:0] head_handle;
   logic [LENGTH_W-1:0] head_length;
   logic [BYTES_W-1:0]  bytes_queued;
   logic [COUNT_W-1:0]  packets_queued;
   logic [BYTES_W-1:0]  space_left;

   modport source (output valid, done_res, head_handle, head_length, bytes_queued,
                   packets_queued, space_left, input ready);
   modport sink   (input valid, done_res, head_handle, head_length, bytes_queued,
                   packets_queued, space_left, output ready);
endinterface

@@ hdl/blpq_desc_ram.sv @@
// Simple dual-port descriptor memory with a registered read port.
`timescale 1ns / 1ps

module blpq_desc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ hdl/byte_limited_packet_queue_unit.sv @@
// Top level of the byte-limited packet descriptor queue.
// For each word, the accept cycle reads the head descriptor from memory,
// and the execute state then updates pointers and counts and loads the result register.
// Results are registered; a new word is accepted only after the last has executed.
// Execution waits while the previous result has not been taken.
// Synchronous reset clears pointers, counts and the byte limit; memory is not cleared.
`timescale 1ns / 1ps

module byte_limited_packet_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   blpq_req_if.sink                      req_bus,
   blpq_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_en,
   input  logic [blpq_pkg::BYTES_W-1:0]  csr_write_data
);
   import blpq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type           state_ff;
   command_type         cmd_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [PTR_W-1:0]    head_ff,  head_in;
   logic [PTR_W-1:0]    tail_ff,  tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [BYTES_W-1:0]  limit_ff;

   logic                rsp_valid_ff;
   logic                done_ff,  done_in;
   logic [HANDLE_W-1:0] hh_ff,    hh_in;
   logic [LENGTH_W-1:0] hl_ff,    hl_in;
   logic [BYTES_W-1:0]  space_ff, space_in;

   logic                accept;
   logic                exec_go;
   logic                push_ok;
   logic [BYTES_W-1:0]  space_now;
   logic [BYTES_W-1:0]  len_ext;
   logic [BYTES_W-1:0]  rd_len_ext;
   logic [DESC_W-1:0]   rd_desc;
   logic [HANDLE_W-1:0] rd_handle;
   logic [LENGTH_W-1:0] rd_length;
   logic                not_empty;
   logic                not_full;

   assign accept  = req_bus.valid && req_bus.ready;
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = (state_ff == ST_IDLE);

   // The head read is issued at accept; the previous word's write has already landed.
   blpq_desc_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (DESC_W)
   ) u_desc_ram (
      .clock      (clock),
      .write_en   (exec_go && push_ok),
      .write_addr (tail_ff),
      .write_data ({handle_ff, length_ff}),
      .read_en    (accept),
      .read_addr  (head_ff),
      .read_data  (rd_desc)
   );

   assign rd_handle  = rd_desc[DESC_W-1:LENGTH_W];
   assign rd_length  = rd_desc[LENGTH_W-1:0];
   assign len_ext    = {{(BYTES_W-LENGTH_W){1'b0}}, length_ff};
   assign rd_len_ext = {{(BYTES_W-LENGTH_W){1'b0}}, rd_length};
   assign space_now  = (bytes_ff >= limit_ff) ? '0 : (limit_ff - bytes_ff);
   assign not_empty  = (count_ff != '0);
   assign not_full   = (count_ff < COUNT_W'(QUEUE_DEPTH));
   assign push_ok    = (cmd_ff == CMD_PUSH) && not_full && (len_ext <= space_now);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      done_in  = 1'b0;
      hh_in    = '0;
      hl_in    = '0;
      unique case (cmd_ff)
         CMD_PUSH: begin
            if (push_ok) begin
               tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
               bytes_in = bytes_ff + len_ext;
               done_in  = 1'b1;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (not_empty) begin
               done_in = 1'b1;
               hh_in   = rd_handle;
               hl_in   = rd_length;
               if (cmd_ff == CMD_POP) begin
                  head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  bytes_in = (bytes_ff >= rd_len_ext) ? bytes_ff - rd_len_ext : '0;
               end
            end
         end
         CMD_PURGE: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            bytes_in = '0;
         end
         default: begin
         end
      endcase
      space_in = (bytes_in >= limit_ff) ? '0 : (limit_ff - bytes_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         hh_ff        <= '0;
         hl_ff        <= '0;
         space_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (exec_go) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
            bytes_ff     <= bytes_in;
            rsp_valid_ff <= 1'b1;
            done_ff      <= done_in;
            hh_ff        <= hh_in;
            hl_ff        <= hl_in;
            space_ff     <= space_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= command_type'(req_bus.command);
         handle_ff <= req_bus.packet_handle;
         length_ff <= req_bus.packet_length;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.done_res       = done_ff;
   assign rsp_bus.head_handle    = hh_ff;
   assign rsp_bus.head_length    = hl_ff;
   assign rsp_bus.bytes_queued   = bytes_ff;
   assign rsp_bus.packets_queued = count_ff;
   assign rsp_bus.space_left     = space_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("Packet count exceeds the queue depth.");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("Empty queue with unequal head and tail pointers.");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("Accepted word did not enter execution.");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("Executed word produced no result.");

   a_purge_clears: assert property (@(posedge clock) disable iff (reset)
      (exec_go && (cmd_ff == CMD_PURGE)) |=> (count_ff == '0 && bytes_ff == '0))
      else $error("Purge left descriptors or bytes in the queue.");

endmodule
